[src/nrmc_pkg.sv]
// Shared types, constants and helper functions for the RMC position parser.
`default_nettype none

package nrmc_pkg;

    // Line buffer limits.
    localparam int unsigned MAX_LINE_BYTES = 256;
    localparam int unsigned LINE_POS_W = $clog2(MAX_LINE_BYTES);
    localparam logic [LINE_POS_W:0] LINE_LAST_COUNT = (LINE_POS_W + 1)'(MAX_LINE_BYTES - 1);

    // Field numbering.
    localparam logic [3:0] FIELD_STOPPED = 4'd15;
    localparam logic [3:0] FIELD_LAST = 4'd7;
    localparam logic [3:0] FIELD_STATUS = 4'd2;
    localparam logic [3:0] FIELD_LAT = 4'd3;
    localparam logic [3:0] FIELD_NS = 4'd4;
    localparam logic [3:0] FIELD_LON = 4'd5;
    localparam logic [3:0] FIELD_EW = 4'd6;
    localparam logic [3:0] FIELD_CHARS_MAX = 4'd15;

    // Number of characters in the degree part of each coordinate.
    localparam logic [3:0] LAT_DEG_CHARS = 4'd2;
    localparam logic [3:0] LON_DEG_CHARS = 4'd3;
    localparam logic [3:0] MIN_CHARS = 4'd7;
    localparam logic [2:0] FRAC_MAX = 3'd7;

    // Characters of interest.
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_NL = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_N = 8'h4E;
    localparam logic [7:0] CH_E = 8'h45;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [2:0] TAG_LEN = 3'd6;

    // Bits of the pending update mask.
    localparam int unsigned UPD_LAT = 0;
    localparam int unsigned UPD_NS_SEEN = 1;
    localparam int unsigned UPD_NS_NORTH = 2;
    localparam int unsigned UPD_LON = 3;
    localparam int unsigned UPD_EW_SEEN = 4;
    localparam int unsigned UPD_EW_EAST = 5;

    // Conversion constants.
    localparam int unsigned MAG_W = 34;
    localparam int unsigned SUM_W = 44;
    localparam logic [SUM_W-1:0] LAT_LIMIT = SUM_W'(64'd2147483647);
    localparam logic [SUM_W-1:0] LON_LIMIT = SUM_W'(64'd17179869183);
    localparam logic [23:0] SCALE_E7 = 24'd10000000;
    // Exact reciprocals of 60: 24-bit dividend with shift 30, 30-bit with shift 36.
    localparam logic [24:0] RECIP60_MIN = 25'd17895698;
    localparam int unsigned RECIP60_MIN_SH = 30;
    localparam logic [30:0] RECIP60_REM = 31'd1145324613;
    localparam int unsigned RECIP60_REM_SH = 36;
    localparam int unsigned CONV_STAGES = 5;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_UPDATED = 2'd0,
        ST_NOT_RMC = 2'd1,
        ST_VOID    = 2'd2
    } t_status;

    // One finished line as handed from the front to the back.
    typedef struct packed {
        t_status     status;
        logic [5:0]  upd;
        logic [9:0]  lat_deg;
        logic [23:0] lat_min;
        logic [2:0]  lat_frac;
        logic [9:0]  lon_deg;
        logic [23:0] lon_min;
        logic [2:0]  lon_frac;
    } t_line_cmd;

    // Expected character of the sentence tag at each position.
    function automatic logic [7:0] rmc_tag(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0: ch = CH_DOLLAR;
            3'd1: ch = CH_G;
            3'd2: ch = CH_P;
            3'd3: ch = CH_R;
            3'd4: ch = CH_M;
            3'd5: ch = CH_C;
            default: ch = CH_NUL;
        endcase
        return ch;
    endfunction

    // Scale 10^(7-frac) that brings the minute integer to 1e7 units.
    function automatic logic [23:0] minute_scale(input logic [2:0] frac);
        logic [23:0] k;
        case (frac)
            3'd0: k = 24'd10000000;
            3'd1: k = 24'd1000000;
            3'd2: k = 24'd100000;
            3'd3: k = 24'd10000;
            3'd4: k = 24'd1000;
            3'd5: k = 24'd100;
            3'd6: k = 24'd10;
            default: k = 24'd1;
        endcase
        return k;
    endfunction

endpackage

`default_nettype wire

[src/nmea_rmc_position_parser.sv]
// Top level of the RMC position parser: front end, command queue and back end.
// Takes one character beat per cycle while the command queue has room; a line ending beat gives one result beat.
// The result beat passes through the command queue, the five-stage minute conversion
// and the result register.
// One character per cycle while results are taken; the queue holds four lines.
// Reset (synchronous, active low) clears line state, stored position and hemispheres (S, W).
`default_nettype none

module nmea_rmc_position_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire  [7:0]   i_s_axis_tdata,   // [7:0] rx_byte
    output logic         o_m_axis_tvalid,
    input  wire          i_m_axis_tready,
    output logic [71:0]  o_m_axis_tdata    // [1:0] status, [33:2] latitude_e7,
                                           // [68:34] longitude_e7, [71:69] zero
);
    import nrmc_pkg::*;

    logic               w_fr_valid;
    logic               w_fr_ready;
    t_line_cmd          w_fr_cmd;
    logic               w_q_valid;
    logic               w_q_ready;
    t_line_cmd          w_q_cmd;
    t_status            w_status;
    logic signed [31:0] w_lat;
    logic signed [34:0] w_lon;

    nrmc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (o_s_axis_tready),
        .i_data      (i_s_axis_tdata),
        .o_cmd_valid (w_fr_valid),
        .i_cmd_ready (w_fr_ready),
        .o_cmd       (w_fr_cmd)
    );

    nrmc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_cmd   (w_fr_cmd),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_cmd   (w_q_cmd)
    );

    nrmc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .o_cmd_ready (w_q_ready),
        .i_cmd       (w_q_cmd),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_status    (w_status),
        .o_lat       (w_lat),
        .o_lon       (w_lon)
    );

    // Result beat packing, first field in the low bits.
    assign o_m_axis_tdata = {3'b000, w_lon, w_lat, w_status};

endmodule

`default_nettype wire

[src/nrmc_front.sv]
// Character front end: tracks the sentence and field state and emits one command per line.
`default_nettype none

module nrmc_front (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  wire  [7:0]               i_data,
    output logic                     o_cmd_valid,
    input  wire                      i_cmd_ready,
    output nrmc_pkg::t_line_cmd      o_cmd
);
    import nrmc_pkg::*;

    logic [LINE_POS_W-1:0] r_pos, n_pos;
    logic                  r_prefix, n_prefix;
    logic [3:0]            r_fnum, n_fnum;
    logic                  r_inside, n_inside;
    logic [3:0]            r_fcc, n_fcc;
    logic                  r_void, n_void;
    logic [9:0]            r_deg, n_deg;
    logic [23:0]           r_min, n_min;
    logic [2:0]            r_frac, n_frac;
    logic                  r_point, n_point;
    logic                  r_stopd, n_stopd;
    logic [9:0]            r_lat_deg, n_lat_deg;
    logic [23:0]           r_lat_min, n_lat_min;
    logic [2:0]            r_lat_frac, n_lat_frac;
    logic [9:0]            r_lon_deg, n_lon_deg;
    logic [23:0]           r_lon_min, n_lon_min;
    logic [2:0]            r_lon_frac, n_lon_frac;
    logic [5:0]            r_upd, n_upd;

    logic                  w_take;
    logic                  w_line_end;

    assign o_ready = i_cmd_ready;
    assign w_take = i_valid && i_cmd_ready;
    assign o_cmd_valid = i_valid && w_line_end;

    // Per-character state update, field close and line close.
    always_comb begin
        logic [3:0]        v_p;
        logic [3:0]        v_deg_chars;
        logic              v_digit;
        logic [3:0]        v_dig;
        logic              v_close;
        logic              v_stop;
        logic [LINE_POS_W:0] v_count;

        n_pos = r_pos;
        n_prefix = r_prefix;
        n_fnum = r_fnum;
        n_inside = r_inside;
        n_fcc = r_fcc;
        n_void = r_void;
        n_deg = r_deg;
        n_min = r_min;
        n_frac = r_frac;
        n_point = r_point;
        n_stopd = r_stopd;
        n_lat_deg = r_lat_deg;
        n_lat_min = r_lat_min;
        n_lat_frac = r_lat_frac;
        n_lon_deg = r_lon_deg;
        n_lon_min = r_lon_min;
        n_lon_frac = r_lon_frac;
        n_upd = r_upd;

        v_p = 4'd0;
        v_deg_chars = (r_fnum == FIELD_LAT) ? LAT_DEG_CHARS : LON_DEG_CHARS;
        v_digit = (i_data >= CH_ZERO) && (i_data <= CH_NINE);
        v_dig = 4'(i_data - CH_ZERO);
        v_close = 1'b0;
        v_stop = 1'b0;
        v_count = (LINE_POS_W + 1)'(r_pos) + (LINE_POS_W + 1)'(1);
        w_line_end = (i_data == CH_NL) || (v_count >= LINE_LAST_COUNT);

        if (r_fnum != FIELD_STOPPED) begin
            if ((r_pos < (LINE_POS_W)'(TAG_LEN)) && (i_data != rmc_tag(r_pos[2:0]))) begin
                n_prefix = 1'b0;
            end
            if (i_data == CH_NUL) begin
                v_close = r_inside;
                v_stop = 1'b1;
                n_inside = 1'b0;
            end else if (i_data == CH_COMMA) begin
                v_close = r_inside;
            end else begin
                // A new field starts with fresh number accumulators.
                if (!r_inside) begin
                    n_inside = 1'b1;
                    n_fcc = 4'd0;
                    n_deg = 10'd0;
                    n_min = 24'd0;
                    n_frac = 3'd0;
                    n_point = 1'b0;
                    n_stopd = 1'b0;
                end
                v_p = n_fcc;
                if ((r_fnum == FIELD_STATUS) && (v_p == 4'd0) && (i_data == CH_V)) begin
                    n_void = 1'b1;
                end else if ((r_fnum == FIELD_LAT) || (r_fnum == FIELD_LON)) begin
                    // Degree part, then up to seven minute characters.
                    if (v_p < v_deg_chars) begin
                        if (!n_stopd) begin
                            if (v_digit) begin
                                n_deg = 10'(14'(n_deg) * 14'd10 + 14'(v_dig));
                            end else begin
                                n_stopd = 1'b1;
                            end
                        end
                    end else if (v_p < v_deg_chars + MIN_CHARS) begin
                        if (v_p == v_deg_chars) begin
                            n_point = 1'b0;
                            n_stopd = 1'b0;
                        end
                        if (!n_stopd) begin
                            if (v_digit) begin
                                n_min = 24'(28'(n_min) * 28'd10 + 28'(v_dig));
                                if (n_point && (n_frac < FRAC_MAX)) begin
                                    n_frac = n_frac + 3'd1;
                                end
                            end else if ((i_data == CH_DOT) && !n_point) begin
                                n_point = 1'b1;
                            end else begin
                                n_stopd = 1'b1;
                            end
                        end
                    end
                end else if ((r_fnum == FIELD_NS) && (v_p == 4'd0)) begin
                    n_upd[UPD_NS_SEEN] = 1'b1;
                    if (i_data == CH_N) begin
                        n_upd[UPD_NS_NORTH] = 1'b1;
                    end
                end else if ((r_fnum == FIELD_EW) && (v_p == 4'd0)) begin
                    n_upd[UPD_EW_SEEN] = 1'b1;
                    if (i_data == CH_E) begin
                        n_upd[UPD_EW_EAST] = 1'b1;
                    end
                end
                if (v_p < FIELD_CHARS_MAX) begin
                    n_fcc = v_p + 4'd1;
                end
            end
            // The line end closes a field still open.
            if (w_line_end && n_inside) begin
                v_close = 1'b1;
            end
        end

        // Field close: latch the raw coordinate and advance the field number.
        if (v_close) begin
            if (r_fnum == FIELD_LAT) begin
                n_lat_deg = n_deg;
                n_lat_min = n_min;
                n_lat_frac = n_frac;
                n_upd[UPD_LAT] = 1'b1;
            end else if (r_fnum == FIELD_LON) begin
                n_lon_deg = n_deg;
                n_lon_min = n_min;
                n_lon_frac = n_frac;
                n_upd[UPD_LON] = 1'b1;
            end
            if (r_fnum < FIELD_LAST) begin
                n_fnum = r_fnum + 4'd1;
            end
            n_inside = 1'b0;
        end
        if (v_stop) begin
            n_fnum = FIELD_STOPPED;
        end

        n_pos = v_count[LINE_POS_W-1:0];

        // Line command built from the state after this character.
        if (!n_prefix) begin
            o_cmd.status = ST_NOT_RMC;
        end else if (n_void) begin
            o_cmd.status = ST_VOID;
        end else begin
            o_cmd.status = ST_UPDATED;
        end
        o_cmd.upd = n_upd;
        o_cmd.lat_deg = n_lat_deg;
        o_cmd.lat_min = n_lat_min;
        o_cmd.lat_frac = n_lat_frac;
        o_cmd.lon_deg = n_lon_deg;
        o_cmd.lon_min = n_lon_min;
        o_cmd.lon_frac = n_lon_frac;

        // A finished line starts the next one from scratch.
        if (w_line_end) begin
            n_pos = '0;
            n_prefix = 1'b1;
            n_fnum = 4'd0;
            n_inside = 1'b0;
            n_fcc = 4'd0;
            n_void = 1'b0;
            n_deg = 10'd0;
            n_min = 24'd0;
            n_frac = 3'd0;
            n_point = 1'b0;
            n_stopd = 1'b0;
            n_lat_deg = 10'd0;
            n_lat_min = 24'd0;
            n_lat_frac = 3'd0;
            n_lon_deg = 10'd0;
            n_lon_min = 24'd0;
            n_lon_frac = 3'd0;
            n_upd = 6'd0;
        end
    end

    // Line state registers, advanced on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_prefix <= 1'b1;
            r_fnum <= 4'd0;
            r_inside <= 1'b0;
            r_fcc <= 4'd0;
            r_void <= 1'b0;
            r_deg <= 10'd0;
            r_min <= 24'd0;
            r_frac <= 3'd0;
            r_point <= 1'b0;
            r_stopd <= 1'b0;
            r_lat_deg <= 10'd0;
            r_lat_min <= 24'd0;
            r_lat_frac <= 3'd0;
            r_lon_deg <= 10'd0;
            r_lon_min <= 24'd0;
            r_lon_frac <= 3'd0;
            r_upd <= 6'd0;
        end else if (w_take) begin
            r_pos <= n_pos;
            r_prefix <= n_prefix;
            r_fnum <= n_fnum;
            r_inside <= n_inside;
            r_fcc <= n_fcc;
            r_void <= n_void;
            r_deg <= n_deg;
            r_min <= n_min;
            r_frac <= n_frac;
            r_point <= n_point;
            r_stopd <= n_stopd;
            r_lat_deg <= n_lat_deg;
            r_lat_min <= n_lat_min;
            r_lat_frac <= n_lat_frac;
            r_lon_deg <= n_lon_deg;
            r_lon_min <= n_lon_min;
            r_lon_frac <= n_lon_frac;
            r_upd <= n_upd;
        end
    end

endmodule

`default_nettype wire

[src/nrmc_fifo.sv]
// Four-entry command queue between the character front end and the conversion back end.
`default_nettype none

module nrmc_fifo (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_ready,
    input  nrmc_pkg::t_line_cmd      i_cmd,
    output logic                     o_valid,
    input  wire                      i_ready,
    output nrmc_pkg::t_line_cmd      o_cmd
);
    import nrmc_pkg::*;

    localparam int unsigned DEPTH = 4;
    localparam int unsigned PTR_W = $clog2(DEPTH);

    t_line_cmd          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [PTR_W:0]     r_count;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_count < (PTR_W + 1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd = r_mem[r_rd_ptr];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + (PTR_W + 1)'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/nrmc_conv.sv]
// Five-stage pipeline that turns degrees and minute digits into a saturated 1e7-degree magnitude.
`default_nettype none

module nrmc_conv (
    input  wire                          i_clk,
    input  wire                          i_en,
    input  wire                          i_is_lon,
    input  wire  [9:0]                   i_deg,
    input  wire  [23:0]                  i_min,
    input  wire  [2:0]                   i_frac,
    output logic [nrmc_pkg::MAG_W-1:0]   o_mag
);
    import nrmc_pkg::*;

    // Stage A: quotient of minutes by 60, scale lookup, degree product.
    logic [23:0]      r_a_min;
    logic [18:0]      r_a_q;
    logic [23:0]      r_a_k;
    logic [33:0]      r_a_dk;
    logic             r_a_lon;
    // Stage B: quotient times scale, remainder.
    logic [42:0]      r_b_a;
    logic [5:0]       r_b_r;
    logic [23:0]      r_b_k;
    logic [33:0]      r_b_dk;
    logic             r_b_lon;
    // Stage C: remainder times scale.
    logic [29:0]      r_c_b;
    logic [42:0]      r_c_a;
    logic [33:0]      r_c_dk;
    logic             r_c_lon;
    // Stage D: that product divided by 60.
    logic [23:0]      r_d_c;
    logic [42:0]      r_d_a;
    logic [33:0]      r_d_dk;
    logic             r_d_lon;

    logic [48:0]      w_q_prod;
    logic [23:0]      w_rem_full;
    logic [60:0]      w_c_prod;
    logic [SUM_W-1:0] w_sum;
    logic [SUM_W-1:0] w_limit;

    assign w_q_prod = 49'(i_min) * 49'(RECIP60_MIN);
    assign w_rem_full = r_a_min - 24'({r_a_q, 6'd0} - {r_a_q, 2'd0});
    assign w_c_prod = 61'(r_c_b) * 61'(RECIP60_REM);
    assign w_sum = SUM_W'(r_d_dk) + SUM_W'(r_d_a) + SUM_W'(r_d_c);
    assign w_limit = r_d_lon ? LON_LIMIT : LAT_LIMIT;

    // Pipeline registers, all held while the back end stalls.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_min <= i_min;
            r_a_q <= w_q_prod[RECIP60_MIN_SH +: 19];
            r_a_k <= minute_scale(i_frac);
            r_a_dk <= 34'(i_deg) * 34'(SCALE_E7);
            r_a_lon <= i_is_lon;

            r_b_a <= 43'(r_a_q) * 43'(r_a_k);
            r_b_r <= w_rem_full[5:0];
            r_b_k <= r_a_k;
            r_b_dk <= r_a_dk;
            r_b_lon <= r_a_lon;

            r_c_b <= 30'(r_b_r) * 30'(r_b_k);
            r_c_a <= r_b_a;
            r_c_dk <= r_b_dk;
            r_c_lon <= r_b_lon;

            r_d_c <= w_c_prod[RECIP60_REM_SH +: 24];
            r_d_a <= r_c_a;
            r_d_dk <= r_c_dk;
            r_d_lon <= r_c_lon;

            o_mag <= (w_sum > w_limit) ? w_limit[MAG_W-1:0] : w_sum[MAG_W-1:0];
        end
    end

endmodule

`default_nettype wire

[src/nrmc_back.sv]
// Back end: converts queued line commands, commits the position and holds the result beat.
`default_nettype none

module nrmc_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cmd_valid,
    output logic                     o_cmd_ready,
    input  nrmc_pkg::t_line_cmd      i_cmd,
    output logic                     o_valid,
    input  wire                      i_ready,
    output nrmc_pkg::t_status        o_status,
    output logic signed [31:0]       o_lat,
    output logic signed [34:0]       o_lon
);
    import nrmc_pkg::*;

    logic                  w_en;
    logic                  w_last_valid;
    logic [MAG_W-1:0]      w_lat_mag;
    logic [MAG_W-1:0]      w_lon_mag;

    logic                  r_pipe_valid [CONV_STAGES];
    t_status               r_pipe_status [CONV_STAGES];
    logic [5:0]            r_pipe_upd [CONV_STAGES];

    logic [30:0]           r_lat_mag, n_lat_mag;
    logic [33:0]           r_lon_mag, n_lon_mag;
    logic [1:0]            r_hemi, n_hemi;
    logic                  r_out_valid;
    t_status               r_out_status;
    logic signed [31:0]    r_out_lat, n_out_lat;
    logic signed [34:0]    r_out_lon, n_out_lon;

    // The whole back end advances when the result register is free.
    assign w_en = !r_out_valid || i_ready;
    assign o_cmd_ready = w_en;
    assign w_last_valid = r_pipe_valid[CONV_STAGES-1];

    assign o_valid = r_out_valid;
    assign o_status = r_out_status;
    assign o_lat = r_out_lat;
    assign o_lon = r_out_lon;

    nrmc_conv u_lat_conv (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_is_lon (1'b0),
        .i_deg    (i_cmd.lat_deg),
        .i_min    (i_cmd.lat_min),
        .i_frac   (i_cmd.lat_frac),
        .o_mag    (w_lat_mag)
    );

    nrmc_conv u_lon_conv (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_is_lon (1'b1),
        .i_deg    (i_cmd.lon_deg),
        .i_min    (i_cmd.lon_min),
        .i_frac   (i_cmd.lon_frac),
        .o_mag    (w_lon_mag)
    );

    // Commit of a valid position line and signed result values.
    always_comb begin
        n_lat_mag = r_lat_mag;
        n_lon_mag = r_lon_mag;
        n_hemi = r_hemi;
        if (w_last_valid && (r_pipe_status[CONV_STAGES-1] == ST_UPDATED)) begin
            if (r_pipe_upd[CONV_STAGES-1][UPD_LAT]) begin
                n_lat_mag = w_lat_mag[30:0];
            end
            if (r_pipe_upd[CONV_STAGES-1][UPD_NS_SEEN]) begin
                n_hemi[0] = r_pipe_upd[CONV_STAGES-1][UPD_NS_NORTH];
            end
            if (r_pipe_upd[CONV_STAGES-1][UPD_LON]) begin
                n_lon_mag = w_lon_mag;
            end
            if (r_pipe_upd[CONV_STAGES-1][UPD_EW_SEEN]) begin
                n_hemi[1] = r_pipe_upd[CONV_STAGES-1][UPD_EW_EAST];
            end
        end
        n_out_lat = n_hemi[0] ? $signed({1'b0, n_lat_mag}) : -$signed({1'b0, n_lat_mag});
        n_out_lon = n_hemi[1] ? $signed({1'b0, n_lon_mag}) : -$signed({1'b0, n_lon_mag});
    end

    // Control pipe alongside the conversion, stored position and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CONV_STAGES; i++) begin
                r_pipe_valid[i] <= 1'b0;
            end
            r_lat_mag <= 31'd0;
            r_lon_mag <= 34'd0;
            r_hemi <= 2'b00;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_pipe_valid[0] <= i_cmd_valid;
            r_pipe_status[0] <= i_cmd.status;
            r_pipe_upd[0] <= i_cmd.upd;
            for (int i = 1; i < CONV_STAGES; i++) begin
                r_pipe_valid[i] <= r_pipe_valid[i-1];
                r_pipe_status[i] <= r_pipe_status[i-1];
                r_pipe_upd[i] <= r_pipe_upd[i-1];
            end
            r_out_valid <= w_last_valid;
            if (w_last_valid) begin
                r_lat_mag <= n_lat_mag;
                r_lon_mag <= n_lon_mag;
                r_hemi <= n_hemi;
                r_out_status <= r_pipe_status[CONV_STAGES-1];
                r_out_lat <= n_out_lat;
                r_out_lon <= n_out_lon;
            end
        end
    end

endmodule

`default_nettype wire

[sim/nmea_rmc_position_parser_tb.sv]
// Self-checking testbench for the RMC position parser: character stream in, fix reports out.
`timescale 1ns / 1ps

module nmea_rmc_position_parser_tb;

    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_PRINTS = 60;
    localparam int unsigned LINE_MAX = nrmc_pkg::MAX_LINE_BYTES;

    // Characters the parser reacts to, and characters the stimulus uses.
    localparam logic [7:0] ASC_NUL = 8'h00;
    localparam logic [7:0] ASC_NL = 8'h0A;
    localparam logic [7:0] ASC_SPACE = 8'h20;
    localparam logic [7:0] ASC_COMMA = 8'h2C;
    localparam logic [7:0] ASC_DOT = 8'h2E;
    localparam logic [7:0] ASC_0 = 8'h30;
    localparam logic [7:0] ASC_9 = 8'h39;
    localparam logic [7:0] ASC_A = 8'h41;
    localparam logic [7:0] ASC_E = 8'h45;
    localparam logic [7:0] ASC_N = 8'h4E;
    localparam logic [7:0] ASC_S = 8'h53;
    localparam logic [7:0] ASC_V = 8'h56;
    localparam logic [7:0] ASC_W = 8'h57;
    localparam logic [47:0] RMC_HEAD = "$GPRMC";

    // Field numbers after empty fields are dropped.
    localparam logic [3:0] FLD_STATUS = 4'd2;
    localparam logic [3:0] FLD_LAT = 4'd3;
    localparam logic [3:0] FLD_NS = 4'd4;
    localparam logic [3:0] FLD_LON = 4'd5;
    localparam logic [3:0] FLD_EW = 4'd6;
    localparam logic [3:0] FLD_LAST = 4'd7;
    localparam logic [3:0] FLD_HALTED = 4'd15;
    localparam logic [3:0] FLD_CHARS_CAP = 4'd15;

    localparam longint unsigned E7 = 64'd10000000;
    localparam longint unsigned LAT_CAP = 64'd2147483647;
    localparam longint unsigned LON_CAP = 64'd17179869183;

    typedef struct {
        nrmc_pkg::t_status status;
        logic [31:0]       lat;
        logic [34:0]       lon;
    } t_fix_report;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata = 8'h00;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [71:0] m_tdata;

    t_fix_report   pending_fix_reports[$];
    logic [7:0]    line_buf[$];
    int unsigned   fail_count = 0;
    int unsigned   reports_checked = 0;
    int unsigned   lines_predicted = 0;
    int unsigned   chars_sent = 0;
    int unsigned   cycle_count = 0;
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_stall_pct = 0;
    logic          hold_request = 1'b0;
    int unsigned   hold_count = 0;

    // Line state of the predictor.
    logic [11:0] ln_pos;
    logic        ln_tag_ok;
    logic [3:0]  ln_field;
    logic        ln_in_field;
    logic [3:0]  ln_fchars;
    logic        ln_void;
    logic [9:0]  ln_deg;
    logic [23:0] ln_min;
    logic [2:0]  ln_frac;
    logic        ln_point;
    logic        ln_stop;
    logic [30:0] ln_lat;
    logic [33:0] ln_lon;
    logic        lat_seen, ns_seen, ns_north, lon_seen, ew_seen, ew_east;

    // Position held across lines; reset is south and west at zero.
    logic [30:0] fix_lat_mag = '0;
    logic [33:0] fix_lon_mag = '0;
    logic        fix_north = 1'b0;
    logic        fix_east = 1'b0;

    nmea_rmc_position_parser u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    // 10 ns clock.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS)
            $display("[%0t] mismatch at report %0d: %s", $realtime, reports_checked, msg);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // Line parser prediction
    // ---------------------------------------------------------------

    function automatic void clear_line_state();
        ln_pos = '0;
        ln_tag_ok = 1'b1;
        ln_field = '0;
        ln_in_field = 1'b0;
        ln_fchars = '0;
        ln_void = 1'b0;
        ln_deg = '0;
        ln_min = '0;
        ln_frac = '0;
        ln_point = 1'b0;
        ln_stop = 1'b0;
        ln_lat = '0;
        ln_lon = '0;
        {lat_seen, ns_seen, ns_north, lon_seen, ew_seen, ew_east} = '0;
    endfunction

    // Degrees plus minutes over 60, in units of 1e-7 degree, truncated and capped.
    function automatic longint unsigned coord_e7(input longint unsigned cap);
        longint unsigned divisor;
        longint unsigned deg;
        longint unsigned mins;
        longint unsigned total;
        int k;
        divisor = 60;
        for (k = 0; k < ln_frac; k++)
            divisor = divisor * 10;
        deg = ln_deg;
        mins = ln_min;
        total = deg * E7 + (mins * E7) / divisor;
        return (total > cap) ? cap : total;
    endfunction

    // One character of a coordinate field: degree digits, then up to seven minute characters.
    function automatic void take_coord_char(input logic [7:0] c, input logic [3:0] deg_chars);
        logic is_digit;
        is_digit = (c >= ASC_0) && (c <= ASC_9);
        if (ln_fchars < deg_chars) begin
            if (!ln_stop) begin
                if (is_digit)
                    ln_deg = ln_deg * 10 + (c - ASC_0);
                else
                    ln_stop = 1'b1;
            end
        end else if (ln_fchars < deg_chars + 7) begin
            if (ln_fchars == deg_chars) begin
                ln_point = 1'b0;
                ln_stop = 1'b0;
            end
            if (!ln_stop) begin
                if (is_digit) begin
                    ln_min = ln_min * 10 + (c - ASC_0);
                    if (ln_point && ln_frac < 3'd7)
                        ln_frac = ln_frac + 1'b1;
                end else if (c == ASC_DOT && !ln_point) begin
                    ln_point = 1'b1;
                end else begin
                    ln_stop = 1'b1;
                end
            end
        end
    endfunction

    function automatic void take_field_char(input logic [7:0] c);
        if (ln_field == FLD_STATUS && ln_fchars == 0 && c == ASC_V) begin
            ln_void = 1'b1;
        end else if (ln_field == FLD_LAT) begin
            take_coord_char(c, 4'd2);
        end else if (ln_field == FLD_LON) begin
            take_coord_char(c, 4'd3);
        end else if (ln_field == FLD_NS && ln_fchars == 0) begin
            ns_seen = 1'b1;
            ns_north = ns_north | (c == ASC_N);
        end else if (ln_field == FLD_EW && ln_fchars == 0) begin
            ew_seen = 1'b1;
            ew_east = ew_east | (c == ASC_E);
        end
        if (ln_fchars < FLD_CHARS_CAP)
            ln_fchars = ln_fchars + 1'b1;
    endfunction

    function automatic void close_field();
        if (ln_field == FLD_LAT) begin
            ln_lat = 31'(coord_e7(LAT_CAP));
            lat_seen = 1'b1;
        end else if (ln_field == FLD_LON) begin
            ln_lon = 34'(coord_e7(LON_CAP));
            lon_seen = 1'b1;
        end
        if (ln_field < FLD_LAST)
            ln_field = ln_field + 1'b1;
        ln_in_field = 1'b0;
    endfunction

    // Advance the parser by one accepted character; a finished line queues its report.
    function automatic void track_rx_char(input logic [7:0] c);
        logic [12:0] count;
        t_fix_report rep;
        if (ln_field != FLD_HALTED) begin
            if (ln_pos < 6 && c != RMC_HEAD[47 - 8 * ln_pos -: 8])
                ln_tag_ok = 1'b0;
            if (c == ASC_NUL) begin
                if (ln_in_field)
                    close_field();
                ln_in_field = 1'b0;
                ln_field = FLD_HALTED;
            end else if (c == ASC_COMMA) begin
                if (ln_in_field)
                    close_field();
            end else begin
                if (!ln_in_field) begin
                    ln_in_field = 1'b1;
                    ln_fchars = '0;
                    ln_deg = '0;
                    ln_min = '0;
                    ln_frac = '0;
                    ln_point = 1'b0;
                    ln_stop = 1'b0;
                end
                take_field_char(c);
            end
        end

        count = ln_pos + 1;
        ln_pos = count[11:0];
        if (c != ASC_NL && count < LINE_MAX - 1)
            return;

        if (ln_in_field && ln_field != FLD_HALTED)
            close_field();

        // Commit only from a valid RMC line with a fix.
        if (!ln_tag_ok) begin
            rep.status = nrmc_pkg::ST_NOT_RMC;
        end else if (ln_void) begin
            rep.status = nrmc_pkg::ST_VOID;
        end else begin
            rep.status = nrmc_pkg::ST_UPDATED;
            if (lat_seen)
                fix_lat_mag = ln_lat;
            if (ns_seen)
                fix_north = ns_north;
            if (lon_seen)
                fix_lon_mag = ln_lon;
            if (ew_seen)
                fix_east = ew_east;
        end
        rep.lat = fix_north ? {1'b0, fix_lat_mag} : 32'd0 - {1'b0, fix_lat_mag};
        rep.lon = fix_east ? {1'b0, fix_lon_mag} : 35'd0 - {1'b0, fix_lon_mag};
        pending_fix_reports.push_back(rep);
        lines_predicted++;
        clear_line_state();
    endfunction

    initial begin
        clear_line_state();
    end

    // Every accepted character beat goes through the predictor.
    always @(posedge clk) begin
        if (rst_n && s_tvalid && s_tready)
            track_rx_char(s_tdata);
    end

    // Receiver: random stalls, or a long hold-off while one is requested.
    always @(posedge clk) begin
        if (!hold_request)
            hold_count <= 0;
        if (hold_request && hold_count < HOLD_CYCLES) begin
            m_tready <= 1'b0;
            hold_count <= hold_count + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result beat with the oldest predicted report.
    always @(posedge clk) begin
        t_fix_report want;
        if (rst_n && m_tvalid && m_tready) begin
            if (pending_fix_reports.size() == 0) begin
                report_mismatch("result beat with no finished line pending");
            end else begin
                want = pending_fix_reports.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch($sformatf("status expected %0d, got %0d",
                                              want.status, m_tdata[1:0]));
                if (m_tdata[33:2] !== want.lat)
                    report_mismatch($sformatf("latitude_e7 expected %0d, got %0d",
                                              $signed(want.lat), $signed(m_tdata[33:2])));
                if (m_tdata[68:34] !== want.lon)
                    report_mismatch($sformatf("longitude_e7 expected %0d, got %0d",
                                              $signed(want.lon), $signed(m_tdata[68:34])));
            end
            reports_checked++;
        end
    end

    // ---------------------------------------------------------------
    // Character stream helpers
    // ---------------------------------------------------------------

    // Offer one character beat after a random idle gap; returns once it is taken.
    task automatic send_rx_char(input logic [7:0] c);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= c;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        chars_sent++;
    endtask

    task automatic send_line_buf();
        int k;
        for (k = 0; k < line_buf.size(); k++)
            send_rx_char(line_buf[k]);
        line_buf = {};
    endtask

    function automatic void put_char(input logic [7:0] c);
        line_buf.push_back(c);
    endfunction

    function automatic void put_text(input string s);
        int k;
        for (k = 0; k < s.len(); k++)
            line_buf.push_back(s[k]);
    endfunction

    function automatic void put_digits(input int n);
        repeat (n) put_char(8'(ASC_0 + $urandom_range(9)));
    endfunction

    task automatic send_text(input string s);
        line_buf = {};
        put_text(s);
        send_line_buf();
    endtask

    // Coordinate with random digit counts; sometimes all nines, zeros or stray characters.
    function automatic void put_coord(input int deg_chars);
        int r;
        r = $urandom_range(99);
        if (r < 4) begin
            put_text("9999999999");
        end else if (r < 8) begin
            put_text("0000000000");
        end else begin
            put_digits(r < 80 ? deg_chars : $urandom_range(deg_chars + 1));
            put_digits(r < 80 ? 2 : $urandom_range(4));
            if ($urandom_range(9) != 0) begin
                put_char(ASC_DOT);
                put_digits($urandom_range(8));
            end
            if ($urandom_range(14) == 0) begin
                put_char(8'(ASC_SPACE + $urandom_range(15)));
                put_digits($urandom_range(3));
            end
        end
    endfunction

    function automatic void put_hemisphere(input logic [7:0] plus_ch, input logic [7:0] minus_ch);
        int r;
        r = $urandom_range(99);
        if (r < 45) begin
            put_char(plus_ch);
        end else if (r < 90) begin
            put_char(minus_ch);
        end else if (r < 95) begin
            put_char(minus_ch);
            put_char(plus_ch);
        end else begin
            put_char(8'(ASC_A + $urandom_range(25)));
        end
    endfunction

    // Field separator, now and then doubled into an empty field.
    function automatic void put_sep();
        put_char(ASC_COMMA);
        if ($urandom_range(11) == 0)
            put_char(ASC_COMMA);
    endfunction

    // Well-formed RMC sentence with random content.
    function automatic void build_rmc_line();
        int r;
        line_buf = {};
        put_text("$GPRMC");
        put_sep();
        if ($urandom_range(9) != 0) begin
            put_digits(6);
            put_text(".00");
        end
        put_sep();
        r = $urandom_range(99);
        if (r < 82)
            put_char(ASC_A);
        else if (r < 97)
            put_char(ASC_V);
        put_sep();
        put_coord(2);
        put_sep();
        put_hemisphere(ASC_N, ASC_S);
        put_sep();
        put_coord(3);
        put_sep();
        put_hemisphere(ASC_E, ASC_W);
        if ($urandom_range(1))
            put_text(",022.4,084.4,230394,003.1,W*6A");
        if ($urandom_range(1))
            put_char(8'h0D);
        put_char(ASC_NL);
    endfunction

    // Spoil a sentence: wrong tag letter, a zero character, or a cut-off tail.
    function automatic void break_line();
        int r;
        int n;
        r = $urandom_range(99);
        if (r < 33) begin
            line_buf[1 + $urandom_range(4)] = 8'(ASC_A + $urandom_range(25));
        end else if (r < 66) begin
            line_buf.insert($urandom_range(line_buf.size() - 1), ASC_NUL);
        end else begin
            n = $urandom_range(line_buf.size() - 2);
            repeat (n) void'(line_buf.pop_back());
            put_char(ASC_NL);
        end
    endfunction

    function automatic void build_noise_line();
        line_buf = {};
        repeat ($urandom_range(30, 1)) put_char(8'($urandom_range(255)));
        put_char(ASC_NL);
    endfunction

    // A line past the length limit, so it is cut without a newline.
    function automatic void build_long_line();
        line_buf = {};
        put_text("$GPRMC,1,A,");
        repeat (260 + $urandom_range(40)) put_char(8'(ASC_SPACE + $urandom_range(94)));
        put_char(ASC_NL);
    endfunction

    task automatic wait_drained();
        while (pending_fix_reports.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    task automatic test_reset_position();
        send_text("$GPGGA,1,2\n");
        send_text("$GPRMC\n");
    endtask

    task automatic test_full_sentence();
        send_text("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\n");
        send_text("$GPRMC,1,A,3351.1234567,S,15112.5,W\n");
    endtask

    task automatic test_extreme_values();
        // All nines overflow both limits; all zeros give zero.
        send_text("$GPRMC,1,A,9999999999,N,9999999999,E\n");
        send_text("$GPRMC,1,A,9959.9999999,S,99959.9999999,W\n");
        send_text("$GPRMC,1,A,0000.0000000,S,00000.0000000,W\n");
    endtask

    task automatic test_void_fix();
        send_text("$GPRMC,1,V,1234.5,N,01234.5,E\n");
        send_text("$GPRMC,1,AV,1234.5,N,01234.5,E\n");
    endtask

    task automatic test_hemisphere_first_char();
        send_text("$GPRMC,1,A,1000.0,SN,10000.0,WE\n");
        send_text("$GPRMC,1,A,1000.0,NS,10000.0,EW\n");
    endtask

    task automatic test_empty_fields();
        send_text("$GPRMC,,A,,5000.0,N\n");
        send_text("$GPRMC,1,A,,,,,4512.75,N\n");
    endtask

    task automatic test_number_junk();
        send_text("$GPRMC,1,A,4-07.0 3,N,12 34.5,E\n");
        send_text("$GPRMC,1,A,12.34.5,N,1234..5,E\n");
        send_text("$GPRMC,1,A,1,N,1.123456789,E\n");
    endtask

    task automatic test_zero_char();
        // Zero inside a coordinate, then zero inside the sentence tag.
        line_buf = {};
        put_text("$GPRMC,1,A,48");
        put_char(ASC_NUL);
        put_text("07.0,N,01131.0,E\n");
        put_text("$GP");
        put_char(ASC_NUL);
        put_text("RMC,1,A,1111.1,N,11111.1,E\n");
        send_line_buf();
    endtask

    task automatic test_extra_fields();
        send_text("$GPRMC,1,A,1111.1,N,11111.1,E,V,V,V,V,V,V,V,V,V,V,9999.9\n");
    endtask

    task automatic test_max_line();
        line_buf = {};
        put_text("$GPRMC,1,A,4807.038,N,01131.000,E,");
        while (line_buf.size() < LINE_MAX - 2)
            put_text("x");
        put_text("xyz\n");
        send_line_buf();
    endtask

    task automatic test_byte_extremes();
        line_buf = {};
        put_char(8'hFF);
        put_char(8'h80);
        put_char(8'h7F);
        put_char(8'h01);
        put_char(ASC_NL);
        send_line_buf();
    endtask

    // Receiver holds off while lines keep coming, so the parser must stall its input.
    task automatic test_input_stall();
        int k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request <= 1'b1;
        for (k = 0; k < 16; k++)
            send_text("\n");
        send_text("$GPRMC,1,A,0130.5,N,00245.25,E\n");
        while (hold_count < HOLD_CYCLES)
            @(posedge clk);
        hold_request <= 1'b0;
    endtask

    task automatic test_random_traffic(input int unsigned send_pct, input int unsigned stall_pct);
        int unsigned chars_from;
        int unsigned lines_from;
        int r;
        send_idle_pct = send_pct;
        recv_stall_pct = stall_pct;
        chars_from = chars_sent;
        lines_from = lines_predicted;
        while (chars_sent - chars_from < 50 || lines_predicted - lines_from < 2) begin
            r = $urandom_range(99);
            if (r < 70) begin
                build_rmc_line();
            end else if (r < 86) begin
                build_rmc_line();
                break_line();
            end else if (r < 98) begin
                build_noise_line();
            end else begin
                build_long_line();
            end
            send_line_buf();
        end
    endtask

    // Run time guard.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** nmea_rmc_position_parser: FAILED **");
        $finish;
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_position();
        test_full_sentence();
        test_extreme_values();
        test_void_fix();
        test_hemisphere_first_char();
        test_empty_fields();
        test_number_junk();
        test_zero_char();
        test_extra_fields();
        test_max_line();
        test_byte_extremes();
        test_input_stall();
        test_random_traffic(0, 0);
        test_random_traffic(70, 0);
        test_random_traffic(0, 70);
        test_random_traffic(25, 25);

        s_tvalid <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending_fix_reports.size() == 0)
            $display("** nmea_rmc_position_parser: PASSED **");
        else
            $display("** nmea_rmc_position_parser: FAILED **");
        $finish;
    end

endmodule

[sim.f]
src/nrmc_pkg.sv
src/nrmc_front.sv
src/nrmc_fifo.sv
src/nrmc_conv.sv
src/nrmc_back.sv
src/nmea_rmc_position_parser.sv
sim/nmea_rmc_position_parser_tb.sv
